>>> src/sge_pkg.sv
`timescale 1ns / 1ps

package sge_pkg;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;

  // Longest pending name before it spills as plain text.
  localparam int NAME_MAX   = 4;
  localparam int NAME_LEN_W = $clog2(NAME_MAX + 1);
  localparam int NAME_IDX_W = $clog2(NAME_MAX);

  localparam int ENTITY_COUNT = 52;
  localparam int ENT_IDX_W    = $clog2(ENTITY_COUNT);

  localparam int KEY_CAP = 4;   // bytes in a key slot
  localparam int VAL_CAP = 8;   // bytes in an expansion slot
  localparam int KEY_W   = 8 * KEY_CAP;
  localparam int VAL_W   = 8 * VAL_CAP;
  localparam int KEY_LEN_W = $clog2(KEY_CAP + 1);
  localparam int VAL_LEN_W = $clog2(VAL_CAP + 1);
  localparam int SUB_IDX_W = $clog2(VAL_CAP);

  // Strings are right-justified: the last character sits in the low byte.
  localparam logic [KEY_W-1:0] KEY_ROM [ENTITY_COUNT] = '{
    KEY_W'("Agr"),  KEY_W'("Bgr"),  KEY_W'("Dgr"),  KEY_W'("EEgr"),
    KEY_W'("Egr"),  KEY_W'("Ggr"),  KEY_W'("Igr"),  KEY_W'("KHgr"),
    KEY_W'("Kgr"),  KEY_W'("Lgr"),  KEY_W'("Mgr"),  KEY_W'("Ngr"),
    KEY_W'("OHgr"), KEY_W'("Ogr"),  KEY_W'("PHgr"), KEY_W'("PSgr"),
    KEY_W'("Pgr"),  KEY_W'("Rgr"),  KEY_W'("Sgr"),  KEY_W'("THgr"),
    KEY_W'("Tgr"),  KEY_W'("Ugr"),  KEY_W'("Xgr"),  KEY_W'("Zgr"),
    KEY_W'("agr"),  KEY_W'("amp"),  KEY_W'("bgr"),  KEY_W'("dgr"),
    KEY_W'("eegr"), KEY_W'("egr"),  KEY_W'("ggr"),  KEY_W'("gt"),
    KEY_W'("igr"),  KEY_W'("kgr"),  KEY_W'("khgr"), KEY_W'("lgr"),
    KEY_W'("lt"),   KEY_W'("mgr"),  KEY_W'("ngr"),  KEY_W'("ogr"),
    KEY_W'("ohgr"), KEY_W'("pgr"),  KEY_W'("phgr"), KEY_W'("psgr"),
    KEY_W'("rgr"),  KEY_W'("sfgr"), KEY_W'("sgr"),  KEY_W'("tgr"),
    KEY_W'("thgr"), KEY_W'("ugr"),  KEY_W'("xgr"),  KEY_W'("zgr")
  };

  localparam logic [VAL_W-1:0] VAL_ROM [ENTITY_COUNT] = '{
    VAL_W'("Alpha"),   VAL_W'("Beta"),    VAL_W'("Delta"),   VAL_W'("Eta"),
    VAL_W'("Epsilon"), VAL_W'("Gamma"),   VAL_W'("Iota"),    VAL_W'("Chi"),
    VAL_W'("Kappa"),   VAL_W'("Lambda"),  VAL_W'("Mu"),      VAL_W'("Nu"),
    VAL_W'("Omega"),   VAL_W'("Omicron"), VAL_W'("Phi"),     VAL_W'("Psi"),
    VAL_W'("Pi"),      VAL_W'("Rho"),     VAL_W'("Sigma"),   VAL_W'("Theta"),
    VAL_W'("Tau"),     VAL_W'("Upsilon"), VAL_W'("Xi"),      VAL_W'("Zeta"),
    VAL_W'("alpha"),   VAL_W'("&"),       VAL_W'("beta"),    VAL_W'("delta"),
    VAL_W'("eta"),     VAL_W'("epsilon"), VAL_W'("gamma"),   VAL_W'(">"),
    VAL_W'("iota"),    VAL_W'("kappa"),   VAL_W'("chi"),     VAL_W'("lambda"),
    VAL_W'("<"),       VAL_W'("mu"),      VAL_W'("nu"),      VAL_W'("omicron"),
    VAL_W'("omega"),   VAL_W'("pi"),      VAL_W'("phi"),     VAL_W'("psi"),
    VAL_W'("rho"),     VAL_W'("s"),       VAL_W'("sigma"),   VAL_W'("tau"),
    VAL_W'("theta"),   VAL_W'("upsilon"), VAL_W'("xi"),      VAL_W'("zeta")
  };

  // Steps the back end walks through for one command, in output order.
  typedef enum logic [2:0] {
    PH_AMP,
    PH_NAME,
    PH_BYTE,
    PH_LT,
    PH_VAL,
    PH_GT,
    PH_TAIL
  } sge_phase_e;

  localparam int PH_COUNT = 7;

  typedef struct packed {
    logic                           pend_en;   // '&' then the pending name
    logic                           byte_en;   // the input byte itself
    logic                           match_en;  // '<' expansion '>'
    logic                           tail_en;   // trailing '&' at end of text
    logic                           last;      // final beat of the string
    logic [NAME_MAX-1:0][7:0]       name;
    logic [NAME_LEN_W-1:0]          name_len;
    logic [7:0]                     data;
    logic [ENT_IDX_W-1:0]           ent_idx;
  } sge_cmd_t;

  typedef struct packed {
    logic                 hit;
    logic [ENT_IDX_W-1:0] idx;
  } sge_hit_t;

  function automatic logic [KEY_LEN_W-1:0] key_len(input logic [KEY_W-1:0] k);
    logic [KEY_LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < KEY_CAP; i++) begin
      if (k[8*i +: 8] != 8'h00) begin
        n = KEY_LEN_W'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [VAL_LEN_W-1:0] val_len(input logic [VAL_W-1:0] v);
    logic [VAL_LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < VAL_CAP; i++) begin
      if (v[8*i +: 8] != 8'h00) begin
        n = VAL_LEN_W'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [VAL_LEN_W-1:0] ent_val_len(input logic [ENT_IDX_W-1:0] e);
    return val_len(VAL_ROM[e]);
  endfunction

  // Character number idx of the expansion of entry e.
  function automatic logic [7:0] val_byte(input logic [ENT_IDX_W-1:0] e,
                                          input logic [SUB_IDX_W-1:0] idx);
    logic [VAL_W-1:0]     v;
    logic [VAL_LEN_W-1:0] n;
    logic [SUB_IDX_W-1:0] pos;
    v   = VAL_ROM[e];
    n   = val_len(v);
    pos = SUB_IDX_W'(n - VAL_LEN_W'(1) - VAL_LEN_W'(idx));
    return v[{pos, 3'b000} +: 8];
  endfunction

  // Exact, case-sensitive compare against every key in parallel.
  function automatic sge_hit_t lookup(input logic [NAME_MAX-1:0][7:0] name,
                                      input logic [NAME_LEN_W-1:0] len);
    sge_hit_t             r;
    logic [KEY_LEN_W-1:0] kl;
    logic                 same;
    r = '0;
    for (int e = 0; e < ENTITY_COUNT; e++) begin
      kl   = key_len(KEY_ROM[e]);
      same = (kl != '0) && (len == NAME_LEN_W'(kl));
      for (int i = 0; i < KEY_CAP; i++) begin
        if (i < int'(kl) && name[i] != KEY_ROM[e][8*(int'(kl) - 1 - i) +: 8]) begin
          same = 1'b0;
        end
      end
      if (same && !r.hit) begin
        r.hit = 1'b1;
        r.idx = ENT_IDX_W'(e);
      end
    end
    return r;
  endfunction

endpackage

>>> src/sge_front.sv
`timescale 1ns / 1ps

module sge_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output sge_pkg::sge_cmd_t cmd_o
);
  import sge_pkg::*;

  logic                     open_q, open_d;
  logic [NAME_LEN_W-1:0]    len_q, len_d;
  logic [NAME_MAX-1:0][7:0] name_q, name_d;
  logic                     accept;
  sge_hit_t                 hit;
  sge_cmd_t                 cmd;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && cmd_ready_i;
  assign hit        = lookup(name_q, len_q);

  always_comb begin
    open_d   = open_q;
    len_d    = len_q;
    name_d   = name_q;
    cmd      = '0;
    cmd.name     = name_q;
    cmd.name_len = len_q;
    cmd.data     = in_byte_i;
    cmd.ent_idx  = hit.idx;
    cmd.last     = in_last_i;

    if (open_q) begin
      if (in_byte_i == CH_SEMI) begin
        if (hit.hit) begin
          cmd.match_en = 1'b1;
        end else begin
          cmd.pend_en = 1'b1;
          cmd.byte_en = 1'b1;
        end
        open_d = 1'b0;
        len_d  = '0;
      end else if (in_byte_i == CH_AMP) begin
        cmd.pend_en = 1'b1;
        len_d       = '0;
      end else if (len_q >= NAME_LEN_W'(NAME_MAX)) begin
        cmd.pend_en = 1'b1;
        cmd.byte_en = 1'b1;
        open_d      = 1'b0;
        len_d       = '0;
      end else begin
        name_d[len_q[NAME_IDX_W-1:0]] = in_byte_i;
        len_d = len_q + NAME_LEN_W'(1);
      end
    end else if (in_byte_i == CH_AMP) begin
      open_d = 1'b1;
      len_d  = '0;
    end else begin
      cmd.byte_en = 1'b1;
    end

    // End of text: flush whatever is still pending, then go idle.
    if (in_last_i) begin
      if (open_d) begin
        if (cmd.pend_en) begin
          cmd.tail_en = 1'b1;
        end else begin
          cmd.pend_en  = 1'b1;
          cmd.name     = name_d;
          cmd.name_len = len_d;
        end
      end
      open_d = 1'b0;
      len_d  = '0;
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept &&
                       (cmd.pend_en || cmd.byte_en || cmd.match_en || cmd.tail_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      len_q  <= '0;
    end else if (accept) begin
      open_q <= open_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      name_q <= name_d;
    end
  end

endmodule

>>> src/sge_cmd_fifo.sv
`timescale 1ns / 1ps

module sge_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sge_pkg::sge_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output sge_pkg::sge_cmd_t cmd_o
);
  import sge_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sge_cmd_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

>>> src/sge_back.sv
`timescale 1ns / 1ps

module sge_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_empty_i,
  input  sge_pkg::sge_cmd_t cmd_i,
  output logic              cmd_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);
  import sge_pkg::*;

  logic                 busy_q, busy_d;
  sge_phase_e           ph_q, ph_d, cur_ph, first_ph, next_ph;
  logic [SUB_IDX_W-1:0] idx_q, idx_d, cur_idx;
  logic [PH_COUNT-1:0]  ph_en;
  logic                 first_found, next_found, stay, done, fire, load;
  logic [VAL_LEN_W-1:0] vlen;
  logic [7:0]           cur_byte;
  logic                 valid_q;
  logic [7:0]           byte_q;
  logic                 last_q;

  assign vlen = ent_val_len(cmd_i.ent_idx);

  always_comb begin
    ph_en          = '0;
    ph_en[PH_AMP]  = cmd_i.pend_en;
    ph_en[PH_NAME] = cmd_i.pend_en && (cmd_i.name_len != '0);
    ph_en[PH_BYTE] = cmd_i.byte_en;
    ph_en[PH_LT]   = cmd_i.match_en;
    ph_en[PH_VAL]  = cmd_i.match_en;
    ph_en[PH_GT]   = cmd_i.match_en;
    ph_en[PH_TAIL] = cmd_i.tail_en;
  end

  // First step of a fresh command.
  always_comb begin
    first_found = 1'b0;
    first_ph    = PH_AMP;
    for (int i = 0; i < PH_COUNT; i++) begin
      if (ph_en[i] && !first_found) begin
        first_found = 1'b1;
        first_ph    = sge_phase_e'(3'(i));
      end
    end
  end

  assign cur_ph  = busy_q ? ph_q : first_ph;
  assign cur_idx = busy_q ? idx_q : '0;

  // Next enabled step after the current one.
  always_comb begin
    next_found = 1'b0;
    next_ph    = PH_AMP;
    for (int i = 0; i < PH_COUNT; i++) begin
      if (ph_en[i] && !next_found && (3'(i) > cur_ph)) begin
        next_found = 1'b1;
        next_ph    = sge_phase_e'(3'(i));
      end
    end
  end

  always_comb begin
    case (cur_ph)
      PH_AMP:  cur_byte = CH_AMP;
      PH_NAME: cur_byte = cmd_i.name[cur_idx[NAME_IDX_W-1:0]];
      PH_BYTE: cur_byte = cmd_i.data;
      PH_LT:   cur_byte = CH_LT;
      PH_VAL:  cur_byte = val_byte(cmd_i.ent_idx, cur_idx);
      PH_GT:   cur_byte = CH_GT;
      PH_TAIL: cur_byte = CH_AMP;
      default: cur_byte = CH_AMP;
    endcase
  end

  always_comb begin
    stay = 1'b0;
    if (cur_ph == PH_NAME) begin
      stay = (NAME_LEN_W'(cur_idx) + NAME_LEN_W'(1)) < cmd_i.name_len;
    end else if (cur_ph == PH_VAL) begin
      stay = (VAL_LEN_W'(cur_idx) + VAL_LEN_W'(1)) < vlen;
    end
  end

  assign done      = !stay && !next_found;
  assign load      = !valid_q || out_ready_i;
  assign fire      = !cmd_empty_i && load;
  assign cmd_pop_o = fire && done;

  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    idx_d  = idx_q;
    if (fire) begin
      if (stay) begin
        busy_d = 1'b1;
        ph_d   = cur_ph;
        idx_d  = cur_idx + SUB_IDX_W'(1);
      end else if (next_found) begin
        busy_d = 1'b1;
        ph_d   = next_ph;
        idx_d  = '0;
      end else begin
        busy_d = 1'b0;
        idx_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      ph_q    <= PH_AMP;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      idx_q  <= idx_d;
      if (load) begin
        valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= cur_byte;
      last_q <= cmd_i.last && done;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

>>> src/sgml_entity_expander.sv
`timescale 1ns / 1ps

// The first beat an input byte causes passes through the command queue and the output register.
// Throughput: one input beat per cycle while the queue has room; one output beat per cycle while
// the master is ready; the front keeps taking input while an expansion of up to 9 beats drains.
// The command queue between front and back sets how far input may run ahead of output.
// Reset: asynchronous, active low; clears the pending entity, the queue and the output valid.
module sgml_entity_expander #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Slave side: one text byte per beat.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_text
  // Master side: one converted byte per beat.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // out_last
);
  import sge_pkg::*;

  sge_cmd_t push_cmd, head_cmd;
  logic     push, full, empty, pop;

  // Front: track the pending entity name, match on ';', and turn each
  // accepted beat into at most one command describing what it emits.
  sge_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_valid_o (push),
    .cmd_ready_i (!full),
    .cmd_o       (push_cmd)
  );

  // Hold commands so the front need not wait on a long expansion until the queue fills.
  sge_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  // Back: walk each command one beat at a time into the output register.
  sge_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (empty),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> bench/sgml_entity_expander_tb.sv
`timescale 1ns / 1ps

module sgml_entity_expander_tb;

  import sge_pkg::CH_AMP;
  import sge_pkg::CH_SEMI;
  import sge_pkg::CH_LT;
  import sge_pkg::CH_GT;

  localparam int ROM_SIZE   = 52;
  localparam int NAME_LIMIT = 4;
  localparam int PHASE_BEATS = 62;   // minimum random input beats per idling phase

  logic       clk_i;
  logic       rst_ni;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;

  sgml_entity_expander u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // One converted byte as it should leave the master side.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  // Entity table: key and expansion, both right-justified (last char in the low byte).
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] val;
  } entity_t;

  text_beat_t expected_text[$];
  text_beat_t head_beat;
  int         errors;
  int         idle_pct;     // sender idles this often, in percent
  int         stall_pct;    // receiver stalls this often, in percent
  int         beats_sent;

  // Own view of the decoder: pending entity and its name bytes.
  logic       name_open;
  logic [7:0] name_bytes [NAME_LIMIT];
  int         name_count;

  // Directed stimulus table.
  logic [7:0] dir_byte [$];
  logic       dir_last [$];
  bit         dir_typed [$];
  string      dir_want [$];

  function automatic entity_t entity_at(input int idx);
    entity_t e;
    e = '0;
    case (idx)
      0:  e = '{"Agr", "Alpha"};      1:  e = '{"Bgr", "Beta"};
      2:  e = '{"Dgr", "Delta"};      3:  e = '{"EEgr", "Eta"};
      4:  e = '{"Egr", "Epsilon"};    5:  e = '{"Ggr", "Gamma"};
      6:  e = '{"Igr", "Iota"};       7:  e = '{"KHgr", "Chi"};
      8:  e = '{"Kgr", "Kappa"};      9:  e = '{"Lgr", "Lambda"};
      10: e = '{"Mgr", "Mu"};         11: e = '{"Ngr", "Nu"};
      12: e = '{"OHgr", "Omega"};     13: e = '{"Ogr", "Omicron"};
      14: e = '{"PHgr", "Phi"};       15: e = '{"PSgr", "Psi"};
      16: e = '{"Pgr", "Pi"};         17: e = '{"Rgr", "Rho"};
      18: e = '{"Sgr", "Sigma"};      19: e = '{"THgr", "Theta"};
      20: e = '{"Tgr", "Tau"};        21: e = '{"Ugr", "Upsilon"};
      22: e = '{"Xgr", "Xi"};         23: e = '{"Zgr", "Zeta"};
      24: e = '{"agr", "alpha"};      25: e = '{"amp", "&"};
      26: e = '{"bgr", "beta"};       27: e = '{"dgr", "delta"};
      28: e = '{"eegr", "eta"};       29: e = '{"egr", "epsilon"};
      30: e = '{"ggr", "gamma"};      31: e = '{"gt", ">"};
      32: e = '{"igr", "iota"};       33: e = '{"kgr", "kappa"};
      34: e = '{"khgr", "chi"};       35: e = '{"lgr", "lambda"};
      36: e = '{"lt", "<"};           37: e = '{"mgr", "mu"};
      38: e = '{"ngr", "nu"};         39: e = '{"ogr", "omicron"};
      40: e = '{"ohgr", "omega"};     41: e = '{"pgr", "pi"};
      42: e = '{"phgr", "phi"};       43: e = '{"psgr", "psi"};
      44: e = '{"rgr", "rho"};        45: e = '{"sfgr", "s"};
      46: e = '{"sgr", "sigma"};      47: e = '{"tgr", "tau"};
      48: e = '{"thgr", "theta"};     49: e = '{"ugr", "upsilon"};
      50: e = '{"xgr", "xi"};         51: e = '{"zgr", "zeta"};
      default: e = '0;
    endcase
    return e;
  endfunction

  // Number of characters in a right-justified string.
  function automatic int char_count(input logic [63:0] s);
    int n;
    n = 0;
    for (int i = 0; i < 8; i++) begin
      if (s[8*i +: 8] != 8'h00) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  function automatic void push_text(input logic [7:0] b);
    text_beat_t nb;
    nb.data = b;
    nb.last = 1'b0;
    expected_text.push_back(nb);
  endfunction

  // '&' then the pending name, unchanged.
  function automatic void push_pending();
    push_text(CH_AMP);
    for (int i = 0; i < name_count; i++) begin
      push_text(name_bytes[i]);
    end
  endfunction

  // Exact match of the pending name against the table; -1 when none.
  function automatic int match_name();
    logic [31:0] key;
    entity_t     e;
    key = '0;
    for (int i = 0; i < name_count; i++) begin
      key = {key[23:0], name_bytes[i]};
    end
    for (int idx = 0; idx < ROM_SIZE; idx++) begin
      e = entity_at(idx);
      if (e.key == key && char_count({32'h0, e.key}) == name_count) begin
        return idx;
      end
    end
    return -1;
  endfunction

  // Advance the decoder by one input byte and queue what it emits.
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    int      first;
    int      hit;
    entity_t e;
    first = expected_text.size();
    if (name_open) begin
      if (b == CH_SEMI) begin
        hit = match_name();
        if (hit >= 0) begin
          e = entity_at(hit);
          push_text(CH_LT);
          for (int i = char_count(e.val) - 1; i >= 0; i--) begin
            push_text(e.val[8*i +: 8]);
          end
          push_text(CH_GT);
        end else begin
          push_pending();
          push_text(b);
        end
        name_open  = 1'b0;
        name_count = 0;
      end else if (b == CH_AMP) begin
        // flush and reopen at the new '&'
        push_pending();
        name_count = 0;
      end else if (name_count >= NAME_LIMIT) begin
        push_pending();
        push_text(b);
        name_open  = 1'b0;
        name_count = 0;
      end else begin
        name_bytes[name_count] = b;
        name_count++;
      end
    end else if (b == CH_AMP) begin
      name_open  = 1'b1;
      name_count = 0;
    end else begin
      push_text(b);
    end
    if (fin) begin
      // end of text spills whatever is still pending, after the byte's own output
      if (name_open) begin
        push_pending();
      end
      name_open  = 1'b0;
      name_count = 0;
      if (expected_text.size() > first) begin
        expected_text[expected_text.size() - 1].last = 1'b1;
      end
    end
  endfunction

  task automatic add_row(input logic [7:0] b, input logic fin, input bit typed,
                         input string want);
    dir_byte.push_back(b);
    dir_last.push_back(fin);
    dir_typed.push_back(typed);
    dir_want.push_back(want);
  endtask

  // Present one text beat and hold it until accepted. Called at a rising edge.
  // A typed row replaces the predicted output by the one written in the table.
  task automatic send_text(input logic [7:0] b, input logic fin, input bit typed,
                           input string want);
    int first;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do begin
      @(posedge clk_i);
    end while (!s_tready);
    first = expected_text.size();
    decode_byte(b, fin);
    if (typed) begin
      while (expected_text.size() > first) begin
        void'(expected_text.pop_back());
      end
      for (int i = 0; i < want.len(); i++) begin
        push_text(want[i]);
      end
      if (fin && want.len() > 0) begin
        expected_text[expected_text.size() - 1].last = 1'b1;
      end
    end
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_text(b, $urandom_range(0, 19) == 0, 1'b0, "");
  endtask

  // Drop valid and hold until every expected beat has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_text.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One random word: half well-formed entities, then near misses and noise.
  task automatic send_word();
    int         pick;
    int         klen;
    int         pos;
    entity_t    e;
    logic [7:0] kb [6];
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      e    = entity_at($urandom_range(0, ROM_SIZE - 1));
      klen = char_count({32'h0, e.key});
      for (int i = 0; i < klen; i++) begin
        kb[i] = e.key[8*(klen - 1 - i) +: 8];
      end
      if (pick >= 50) begin
        // near miss: flip case, drop the tail or add one more char
        case ($urandom_range(0, 2))
          0: begin
            pos     = $urandom_range(0, klen - 1);
            kb[pos] = kb[pos] ^ 8'h20;
          end
          1: klen--;
          default: begin
            kb[klen] = 8'($urandom_range(8'h41, 8'h7A));
            klen++;
          end
        endcase
      end
      send_byte(CH_AMP);
      for (int i = 0; i < klen; i++) begin
        send_byte(kb[i]);
      end
      send_byte(CH_SEMI);
    end else if (pick < 75) begin
      // name runs past the limit
      send_byte(CH_AMP);
      repeat ($urandom_range(5, 6)) begin
        send_byte(8'($urandom_range(8'h41, 8'h7A)));
      end
    end else if (pick < 83) begin
      send_byte(CH_AMP);
      case ($urandom_range(0, 2))
        0: send_byte(CH_SEMI);
        1: send_byte(CH_AMP);
        default: send_byte(8'($urandom_range(8'h61, 8'h7A)));
      endcase
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver: random stall, then compare every accepted beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual data=%02h last=%0b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        head_beat = expected_text.pop_front();
        if (m_tdata !== head_beat.data) begin
          $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                   $time, head_beat.data, m_tdata);
          errors++;
        end
        if (m_tlast !== head_beat.last) begin
          $display("%0t: out_last mismatch, expected %0b, actual %0b",
                   $time, head_beat.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    s_tvalid   = 1'b0;
    s_tdata    = 8'h00;
    s_tlast    = 1'b0;
    m_tready   = 1'b0;
    errors     = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    beats_sent = 0;
    name_open  = 1'b0;
    name_count = 0;
    for (int i = 0; i < NAME_LIMIT; i++) begin
      name_bytes[i] = 8'h00;
    end

    // byte, end of text, typed, expected text
    add_row(8'h00,   1'b0, 1'b0, "");
    add_row(8'hFF,   1'b1, 1'b0, "");
    add_row(CH_AMP,  1'b0, 1'b1, "");
    add_row("a",     1'b0, 1'b1, "");
    add_row("m",     1'b0, 1'b1, "");
    add_row("p",     1'b0, 1'b1, "");
    add_row(CH_SEMI, 1'b0, 1'b1, "<&>");
    // empty name passes through
    add_row(CH_AMP,  1'b0, 1'b1, "");
    add_row(CH_SEMI, 1'b0, 1'b1, "&;");
    // a second '&' flushes the first name
    add_row(CH_AMP,  1'b0, 1'b1, "");
    add_row("l",     1'b0, 1'b1, "");
    add_row("t",     1'b0, 1'b1, "");
    add_row(CH_AMP,  1'b0, 1'b1, "&lt");
    // match is case-sensitive
    add_row("g",     1'b0, 1'b1, "");
    add_row("T",     1'b0, 1'b1, "");
    add_row(CH_SEMI, 1'b0, 1'b1, "&gT;");
    // longest name that still matches
    add_row(CH_AMP,  1'b0, 1'b1, "");
    add_row("s",     1'b0, 1'b1, "");
    add_row("f",     1'b0, 1'b1, "");
    add_row("g",     1'b0, 1'b1, "");
    add_row("r",     1'b0, 1'b1, "");
    add_row(CH_SEMI, 1'b0, 1'b1, "<s>");
    // one byte past the name limit, also the end of the text
    add_row(CH_AMP,  1'b0, 1'b1, "");
    add_row("p",     1'b0, 1'b1, "");
    add_row("h",     1'b0, 1'b1, "");
    add_row("g",     1'b0, 1'b1, "");
    add_row("r",     1'b0, 1'b1, "");
    add_row("x",     1'b1, 1'b1, "&phgrx");
    // lone '&' as the final byte comes out literally
    add_row(CH_AMP,  1'b1, 1'b1, "&");

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < dir_byte.size(); i++) begin
      send_text(dir_byte[i], dir_last[i], dir_typed[i], dir_want[i]);
    end
    drain();

    // no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 24 : 0;
      stall_pct <= (ph == 2) ? 78 : (ph == 3) ? 24 : 0;
      beats_sent = 0;
      while (beats_sent < PHASE_BEATS) begin
        send_word();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d beats outstanding", $time, expected_text.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
src/sge_pkg.sv
src/sge_front.sv
src/sge_cmd_fifo.sv
src/sge_back.sv
src/sgml_entity_expander.sv
bench/sgml_entity_expander_tb.sv
